// ----- rtl/epbr_pkg.sv -----
// Shared types, codes and constants for the emulation prevention byte remover.
package epbr_pkg;

  localparam int PosBitsDefault     = 24;
  localparam int HeldZeroMaxDefault = 255;
  localparam int EposW              = 24;
  localparam int QueueDepth         = 2;

  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] ByteEpb  = 8'h03;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_ZZ_LOW   = 3'd1,
    ERR_AFTER_EP = 3'd2,
    ERR_END_ZERO = 3'd3,
    ERR_HELD_OVF = 3'd4
  } epbr_err_e;

  // Item as classified by the front part, carried through the queue.
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             vcl;
    logic             removed;
    logic [EposW-1:0] epos;
    epbr_err_e        err;
    logic             end_zero_run;
  } epbr_item_t;

endpackage

// ----- rtl/emulation_prevention_byte_remover.sv -----
// Path: an accepted item is written into the queue, then registered in the back part's result register.
// Throughput: one item per cycle while no result is held back by out_stall_i;
//   a two-item queue lets the front keep taking bytes while a result waits on out_stall_i.
// Reset (rst_ni low, asynchronous): zero run, post-removal flag, byte index, held-zero
//   count, queue pointers and output valid all clear; no clearing pass is needed.
module emulation_prevention_byte_remover #(
  parameter int POSITION_BITS = epbr_pkg::PosBitsDefault,
  parameter int HELD_ZERO_MAX = epbr_pkg::HeldZeroMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_in_unit_i,
  input  logic        vcl_unit_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        byte_valid_o,
  output logic [7:0]  out_byte_o,
  output logic [7:0]  zeros_before_o,
  output logic        epb_removed_o,
  output logic [23:0] epb_position_o,
  output logic        unit_end_o,
  output logic [7:0]  dropped_zeros_o,
  output logic [2:0]  error_code_o
);
  import epbr_pkg::*;

  epbr_item_t front_item;
  epbr_item_t queue_item;
  logic       accept;
  logic       queue_full, queue_empty, back_pop;

  // Stall the input only when the queue has no room; the back part drains it
  // independently of the front.
  assign in_stall_o = queue_full;
  assign accept     = in_valid_i && !queue_full;

  // Classify each item against the zero-run state and push it into the queue.
  epbr_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .last_in_unit_i (last_in_unit_i),
    .vcl_unit_i     (vcl_unit_i),
    .item_o         (front_item)
  );

  // Decouple the two parts so each can stall on its own.
  epbr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (back_pop),
    .empty_o     (queue_empty),
    .pop_item_o  (queue_item)
  );

  // Apply held-zero bookkeeping and register the result item.
  epbr_back #(
    .HELD_ZERO_MAX(HELD_ZERO_MAX)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .have_item_i     (!queue_empty),
    .item_i          (queue_item),
    .pop_o           (back_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .byte_valid_o    (byte_valid_o),
    .out_byte_o      (out_byte_o),
    .zeros_before_o  (zeros_before_o),
    .epb_removed_o   (epb_removed_o),
    .epb_position_o  (epb_position_o),
    .unit_end_o      (unit_end_o),
    .dropped_zeros_o (dropped_zeros_o),
    .error_code_o    (error_code_o)
  );

endmodule

// ----- rtl/epbr_front.sv -----
// Front part: accept bytes, track the zero run and position, classify each item.
module epbr_front #(
  parameter int POSITION_BITS = epbr_pkg::PosBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               last_in_unit_i,
  input  logic               vcl_unit_i,
  output epbr_pkg::epbr_item_t item_o
);
  import epbr_pkg::*;

  localparam int CopyW = (POSITION_BITS < EposW) ? POSITION_BITS : EposW;

  logic [1:0]               zero_run_q, zero_run_d;
  logic                     after_ep_q, after_ep_d;
  logic [POSITION_BITS-1:0] byte_index_q, byte_index_d;
  logic                     removed;

  assign removed = (zero_run_q == 2'd2) && (in_byte_i == ByteEpb);

  always_comb begin
    item_o.data    = in_byte_i;
    item_o.last    = last_in_unit_i;
    item_o.vcl     = vcl_unit_i;
    item_o.removed = removed;
    item_o.epos    = removed ? EposW'(byte_index_q[CopyW-1:0]) : '0;
    item_o.err     = ERR_NONE;
    if (after_ep_q && (in_byte_i > ByteEpb)) begin
      item_o.err = ERR_AFTER_EP;
    end
    if ((zero_run_q == 2'd2) && (in_byte_i < ByteEpb)) begin
      item_o.err = ERR_ZZ_LOW;
    end

    if (removed) begin
      zero_run_d = 2'd0;
    end else if (in_byte_i == ByteZero) begin
      zero_run_d = (zero_run_q == 2'd2) ? 2'd2 : zero_run_q + 2'd1;
    end else begin
      zero_run_d = 2'd0;
    end
    item_o.end_zero_run = (zero_run_d != 2'd0);
    after_ep_d = removed;
    byte_index_d = byte_index_q + POSITION_BITS'(1);

    if (last_in_unit_i) begin
      zero_run_d   = 2'd0;
      after_ep_d   = 1'b0;
      byte_index_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q   <= 2'd0;
      after_ep_q   <= 1'b0;
      byte_index_q <= '0;
    end else if (accept_i) begin
      zero_run_q   <= zero_run_d;
      after_ep_q   <= after_ep_d;
      byte_index_q <= byte_index_d;
    end
  end

endmodule

// ----- rtl/epbr_queue.sv -----
// Short queue of classified items between the front and back parts.
module epbr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  epbr_pkg::epbr_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output epbr_pkg::epbr_item_t pop_item_o
);
  import epbr_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  epbr_item_t      entries_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = entries_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/epbr_back.sv -----
// Back part: hold VCL zeros, release or drop them, and register each result.
module epbr_back #(
  parameter int HELD_ZERO_MAX = epbr_pkg::HeldZeroMaxDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 have_item_i,
  input  epbr_pkg::epbr_item_t item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 byte_valid_o,
  output logic [7:0]           out_byte_o,
  output logic [7:0]           zeros_before_o,
  output logic                 epb_removed_o,
  output logic [23:0]          epb_position_o,
  output logic                 unit_end_o,
  output logic [7:0]           dropped_zeros_o,
  output logic [2:0]           error_code_o
);
  import epbr_pkg::*;

  localparam int         LimitInt  = (HELD_ZERO_MAX > 255) ? 255 : HELD_ZERO_MAX;
  localparam logic [7:0] HeldLimit = 8'(LimitInt);

  logic       out_valid_q;
  logic [7:0] held_q, held_d;
  logic       bv_d, ovf;
  logic [7:0] ob_d, zb_d, drop_d;
  epbr_err_e  err_d;

  logic       bv_q, rm_q, end_q;
  logic [7:0] ob_q, zb_q, drop_q;
  logic [23:0] pos_q;
  epbr_err_e  err_q;

  assign pop_o = have_item_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    held_d = held_q;
    bv_d   = 1'b0;
    ob_d   = 8'd0;
    zb_d   = 8'd0;
    drop_d = 8'd0;
    ovf    = 1'b0;
    if (item_i.removed) begin
      bv_d = 1'b0;
    end else if (item_i.vcl && (item_i.data == ByteZero)) begin
      if (held_q >= HeldLimit) begin
        bv_d   = 1'b1;
        zb_d   = held_q;
        held_d = 8'd0;
        ovf    = 1'b1;
      end else begin
        held_d = held_q + 8'd1;
      end
    end else begin
      bv_d   = 1'b1;
      ob_d   = item_i.data;
      zb_d   = held_q;
      held_d = 8'd0;
    end
    if (item_i.last) begin
      drop_d = item_i.vcl ? held_d : 8'd0;
      held_d = 8'd0;
    end
    if (item_i.err != ERR_NONE) begin
      err_d = item_i.err;
    end else if (item_i.last && item_i.end_zero_run) begin
      err_d = ERR_END_ZERO;
    end else if (ovf) begin
      err_d = ERR_HELD_OVF;
    end else begin
      err_d = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_q      <= 8'd0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        held_q      <= held_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bv_q   <= bv_d;
      ob_q   <= ob_d;
      zb_q   <= zb_d;
      rm_q   <= item_i.removed;
      pos_q  <= item_i.epos;
      end_q  <= item_i.last;
      drop_q <= drop_d;
      err_q  <= err_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_valid_o    = bv_q;
  assign out_byte_o      = ob_q;
  assign zeros_before_o  = zb_q;
  assign epb_removed_o   = rm_q;
  assign epb_position_o  = pos_q;
  assign unit_end_o      = end_q;
  assign dropped_zeros_o = drop_q;
  assign error_code_o    = err_q;

endmodule

// ----- rtl/epbr_assert.sv -----
// Port-level assertions for the emulation prevention byte remover, with bind.
module epbr_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        byte_valid_o,
  input logic [7:0]  out_byte_o,
  input logic [7:0]  zeros_before_o,
  input logic        epb_removed_o,
  input logic [23:0] epb_position_o,
  input logic        unit_end_o,
  input logic [7:0]  dropped_zeros_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_removed_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(byte_valid_o && epb_removed_o))
    else $error("removed prevention byte also emitted");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !epb_removed_o |-> epb_position_o == 24'd0)
    else $error("position reported without removal");

  a_drop_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !unit_end_o |-> dropped_zeros_o == 8'd0)
    else $error("zeros dropped before unit end");

  a_no_byte_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> out_byte_o == 8'd0 && zeros_before_o == 8'd0)
    else $error("byte fields set on result without emitted byte");

endmodule

bind emulation_prevention_byte_remover epbr_assert u_epbr_assert (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .byte_valid_o    (byte_valid_o),
  .out_byte_o      (out_byte_o),
  .zeros_before_o  (zeros_before_o),
  .epb_removed_o   (epb_removed_o),
  .epb_position_o  (epb_position_o),
  .unit_end_o      (unit_end_o),
  .dropped_zeros_o (dropped_zeros_o)
);
